// File: rtl/xcps_pkg.sv
package xcps_pkg;

  // default store depth
  localparam int PARTICLE_SLOTS_DEF = 1024;

  // item kinds carried in tuser
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SOLVE = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // one particle as held in the store
  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] px;
    logic [31:0] py;
    logic [23:0] w;
    logic [30:0] r;
  } particle_t;

  localparam int PARTICLE_W = $bits(particle_t);

  // status of the iterative units
  typedef struct packed {
    logic        done;
    logic [31:0] value;
  } unit_res_t;

  // clamp to the signed 32-bit range
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    logic [31:0] res;
    if (v > 34'sh0_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// File: rtl/xcps_mem.sv
module xcps_mem
  import xcps_pkg::*;
#(
  parameter int DEPTH = PARTICLE_SLOTS_DEF,
  parameter int AW    = $clog2(PARTICLE_SLOTS_DEF)
) (
  input  logic      clk_i,
  input  logic      we_i,
  input  logic [AW-1:0] addr_i,
  input  particle_t wdata_i,
  output particle_t rdata_o
);

  particle_t mem [DEPTH];
  particle_t rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/xcps_sqrt.sv
module xcps_sqrt
  import xcps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output unit_res_t   res_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [35:0] t, trial;
  logic [33:0] rem_d;
  logic [31:0] root_d;

  // one result bit per step
  always_comb begin
    t     = {rem_q, rad_q[63:62]};
    trial = {2'b00, root_q, 2'b01};
    if (t >= trial) begin
      rem_d  = 34'(t - trial);
      root_d = {root_q[30:0], 1'b1};
    end else begin
      rem_d  = t[33:0];
      root_d = {root_q[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = root_q;

endmodule

// File: rtl/xcps_div.sv
module xcps_div
  import xcps_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [32:0] divisor_i,
  output unit_res_t   res_o
);

  // quotient is known to fit 32 bits, so the upper half seeds the remainder
  logic [32:0] rem_q, dv_q;
  logic [31:0] lo_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [33:0] t;
  logic [32:0] rem_d;
  logic        qbit;

  // restoring step
  always_comb begin
    t = {rem_q, lo_q[31]};
    if (t >= {1'b0, dv_q}) begin
      rem_d = 33'(t - {1'b0, dv_q});
      qbit  = 1'b1;
    end else begin
      rem_d = t[32:0];
      qbit  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, dividend_i[63:32]};
      lo_q  <= dividend_i[31:0];
      dv_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      lo_q  <= {lo_q[30:0], qbit};
    end
  end

  assign res_o.done  = done_q;
  assign res_o.value = lo_q;

endmodule

// File: rtl/xpbd_collision_pair_solver_top.sv
// a solve with overlap runs a 32-step square root and then six 32-step divisions
// through one shared divider; a coincident pair and a pair without overlap
// skip both
// throughput: one item at a time, the input is ready again in the same cycle as the result turns valid
// reset: asynchronous active low, clears control and the compliance register;
// the particle store is not cleared and holds nothing defined until written
module xpbd_collision_pair_solver_top
  import xcps_pkg::*;
#(
  parameter int PARTICLE_SLOTS = PARTICLE_SLOTS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_wr_en_i,
  input  logic [31:0]  cfg_wr_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // first_index, second_index, load_x, load_y, load_inverse_mass, load_radius, pad
  input  logic [143:0] s_axis_tdata,
  // op
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // out_x, out_y, out_previous_x, out_previous_y
  output logic [127:0] m_axis_tdata,
  // overlap_fixed, degenerate
  output logic [1:0]   m_axis_tuser
);

  localparam int AW = $clog2(PARTICLE_SLOTS);
  localparam int SL = (PARTICLE_SLOTS > 1024) ? 1024 : PARTICLE_SLOTS;
  localparam int RECIP = (PARTICLE_SLOTS > 1024) ? 0 : ((1 << 20) + SL - 1) / SL;
  localparam logic [20:0] RECIP_W = 21'(RECIP);
  localparam logic [10:0] SLOTS_W = 11'(SL);

  typedef enum logic [4:0] {
    S_IDLE, S_WR, S_RDA, S_RDB, S_CAPB, S_DIFF, S_SQX, S_SQY, S_WSQ, S_CHK,
    S_SQRT, S_MUL, S_DIVS, S_DIVW, S_UPD, S_WA, S_WB, S_DONE
  } state_e;

  state_e      state_q;
  logic [31:0] comp_q;
  logic [1:0]  op_q;
  logic [AW-1:0] a_q, b_q;
  logic [31:0] ldx_q, ldy_q;
  logic [23:0] ldw_q;
  logic [30:0] ldr_q;
  particle_t   pa_q, pb_q;
  logic signed [32:0] ex_q, ey_q;
  logic [31:0] mex_q, mey_q, want_q, dist_q, err_q;
  logic [32:0] den_q;
  logic [63:0] sx_q, sy_q, ww_q, prod_q;
  logic [31:0] quot_q [6];
  logic [2:0]  job_q;
  logic [31:0] nxa_q, nya_q, nxb_q, nyb_q;
  logic        fixed_q, degen_q;
  logic        ovld_q;
  logic [127:0] odata_q;
  logic [1:0]  ouser_q;

  // index reduction by reciprocal multiply
  function automatic logic [AW-1:0] reduce(input logic [9:0] v);
    logic [30:0] prod;
    logic [10:0] q;
    logic [21:0] back;
    logic [9:0]  red;
    logic [16:0] ext;
    prod = 31'({21'd0, v} * RECIP_W);
    q    = prod[30:20];
    back = 22'(q * SLOTS_W);
    red  = (PARTICLE_SLOTS > 1024) ? v : 10'(v - back[9:0]);
    ext  = {7'd0, red};
    return ext[AW-1:0];
  endfunction

  // store port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  particle_t     mem_wdata, mem_rdata;

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = a_q;
    mem_wdata = pa_q;
    case (state_q)
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = '{x: ldx_q, y: ldy_q, px: ldx_q, py: ldy_q, w: ldw_q, r: ldr_q};
      end
      S_RDB: mem_addr = b_q;
      S_WA: begin
        mem_we    = 1'b1;
        mem_wdata = '{x: nxa_q, y: nya_q, px: pa_q.x, py: pa_q.y, w: pa_q.w, r: pa_q.r};
      end
      S_WB: begin
        mem_we    = 1'b1;
        mem_addr  = b_q;
        mem_wdata = '{x: nxb_q, y: nyb_q, px: pb_q.x, py: pb_q.y, w: pb_q.w, r: pb_q.r};
      end
      default: mem_addr = a_q;
    endcase
  end

  xcps_mem #(.DEPTH(PARTICLE_SLOTS), .AW(AW)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // overlap test on the squared distance
  logic [64:0] d2;
  logic        d2_zero, solve_go;
  always_comb begin
    d2       = {1'b0, sx_q} + {1'b0, sy_q};
    d2_zero  = (d2 == 65'd0);
    solve_go = !d2[64] && (d2[63:0] < ww_q) && (den_q != 33'd0);
  end

  // square root unit
  unit_res_t sq_res;
  xcps_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_CHK && !d2_zero && solve_go),
    .radicand_i (d2[63:0]),
    .res_o      (sq_res)
  );

  // multiplier operands for the shared divider, by job
  logic [31:0] mul_a, mul_b;
  always_comb begin
    case (job_q)
      3'd0: begin mul_a = err_q; mul_b = {8'd0, pa_q.w}; end
      3'd1: begin mul_a = err_q; mul_b = {8'd0, pb_q.w}; end
      3'd2: begin mul_a = mex_q; mul_b = quot_q[0]; end
      3'd3: begin mul_a = mey_q; mul_b = quot_q[0]; end
      3'd4: begin mul_a = mex_q; mul_b = quot_q[1]; end
      default: begin mul_a = mey_q; mul_b = quot_q[1]; end
    endcase
  end

  unit_res_t dv_res;
  xcps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_DIVS),
    .dividend_i (prod_q),
    .divisor_i  ((job_q < 3'd2) ? den_q : {1'b0, dist_q}),
    .res_o      (dv_res)
  );

  // position updates with saturation
  logic signed [33:0] ax, ay, bx, by;
  logic [31:0] nxa, nya, nxb, nyb;
  always_comb begin
    ax  = 34'(signed'(pa_q.x));
    ay  = 34'(signed'(pa_q.y));
    bx  = 34'(signed'(pb_q.x));
    by  = 34'(signed'(pb_q.y));
    nxa = sat34(ex_q[32] ? ax + signed'({2'b00, quot_q[2]}) : ax - signed'({2'b00, quot_q[2]}));
    nya = sat34(ey_q[32] ? ay + signed'({2'b00, quot_q[3]}) : ay - signed'({2'b00, quot_q[3]}));
    nxb = sat34(ex_q[32] ? bx - signed'({2'b00, quot_q[4]}) : bx + signed'({2'b00, quot_q[4]}));
    nyb = sat34(ey_q[32] ? by - signed'({2'b00, quot_q[5]}) : by + signed'({2'b00, quot_q[5]}));
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

  // sequencer, config register and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      comp_q  <= '0;
      ovld_q  <= 1'b0;
      job_q   <= '0;
    end else begin
      if (cfg_wr_en_i) begin
        comp_q <= cfg_wr_data_i;
      end
      if (ovld_q && m_axis_tready) begin
        ovld_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            op_q  <= s_axis_tuser;
            a_q   <= reduce(s_axis_tdata[9:0]);
            b_q   <= reduce(s_axis_tdata[19:10]);
            ldx_q <= s_axis_tdata[51:20];
            ldy_q <= s_axis_tdata[83:52];
            ldw_q <= s_axis_tdata[107:84];
            ldr_q <= s_axis_tdata[138:108];
            state_q <= (s_axis_tuser == OP_WRITE) ? S_WR : S_RDA;
          end
        end
        S_WR: begin
          nxa_q   <= ldx_q;
          nya_q   <= ldy_q;
          pa_q.px <= ldx_q;
          pa_q.py <= ldy_q;
          fixed_q <= 1'b0;
          degen_q <= 1'b0;
          state_q <= S_DONE;
        end
        S_RDA: state_q <= S_RDB;
        S_RDB: begin
          pa_q    <= mem_rdata;
          nxa_q   <= mem_rdata.x;
          nya_q   <= mem_rdata.y;
          fixed_q <= 1'b0;
          degen_q <= 1'b0;
          state_q <= (op_q == OP_SOLVE) ? S_CAPB : S_DONE;
        end
        S_CAPB: begin
          pb_q    <= mem_rdata;
          state_q <= S_DIFF;
        end
        S_DIFF: begin
          ex_q   <= 33'(signed'(pb_q.x)) - 33'(signed'(pa_q.x));
          ey_q   <= 33'(signed'(pb_q.y)) - 33'(signed'(pa_q.y));
          want_q <= {1'b0, pa_q.r} + {1'b0, pb_q.r};
          den_q  <= {9'd0, pa_q.w} + {9'd0, pb_q.w} + {1'b0, comp_q};
          state_q <= S_SQX;
        end
        S_SQX: begin
          mex_q   <= ex_q[32] ? 32'(-ex_q) : ex_q[31:0];
          mey_q   <= ey_q[32] ? 32'(-ey_q) : ey_q[31:0];
          state_q <= S_SQY;
        end
        S_SQY: begin
          sx_q    <= {32'd0, mex_q} * {32'd0, mex_q};
          state_q <= S_WSQ;
        end
        S_WSQ: begin
          sy_q    <= {32'd0, mey_q} * {32'd0, mey_q};
          ww_q    <= {32'd0, want_q} * {32'd0, want_q};
          state_q <= S_CHK;
        end
        S_CHK: begin
          // coincident pair leaves everything; otherwise copy previous first
          nxa_q <= pa_q.x;
          nya_q <= pa_q.y;
          nxb_q <= pb_q.x;
          nyb_q <= pb_q.y;
          if (d2_zero) begin
            degen_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            pa_q.px <= pa_q.x;
            pa_q.py <= pa_q.y;
            if (solve_go) begin
              fixed_q <= 1'b1;
              state_q <= S_SQRT;
            end else begin
              state_q <= S_WA;
            end
          end
        end
        S_SQRT: begin
          if (sq_res.done) begin
            dist_q  <= sq_res.value;
            err_q   <= want_q - sq_res.value;
            job_q   <= '0;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          prod_q  <= {32'd0, mul_a} * {32'd0, mul_b};
          state_q <= S_DIVS;
        end
        S_DIVS: state_q <= S_DIVW;
        S_DIVW: begin
          if (dv_res.done) begin
            quot_q[job_q] <= dv_res.value;
            if (job_q == 3'd5) begin
              state_q <= S_UPD;
            end else begin
              job_q   <= job_q + 3'd1;
              state_q <= S_MUL;
            end
          end
        end
        S_UPD: begin
          nxa_q   <= nxa;
          nya_q   <= nya;
          nxb_q   <= nxb;
          nyb_q   <= nyb;
          state_q <= S_WA;
        end
        S_WA: state_q <= S_WB;
        S_WB: state_q <= S_DONE;
        S_DONE: begin
          if (!ovld_q || m_axis_tready) begin
            ovld_q  <= 1'b1;
            odata_q <= {pa_q.py, pa_q.px, nya_q, nxa_q};
            ouser_q <= {degen_q, fixed_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
